>>> hdl/dmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared types and constants for the decimal money string parser.
// ----------------------------------------------------------------------------
package dmp_pkg;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // largest whole part that may still take one more digit:
   // (largest signed 64-bit value - 9) / 10
   localparam logic [62:0] WHOLE_LIMIT = 63'd922337203685477579;

   localparam logic [3:0] ROUND_DIGIT = 4'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_MALFORMED = 2'd3;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_WHOLE = 2'd1,
      PH_FRAC  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       last;
   } dmp_req_type;

   typedef struct packed {
      logic signed [63:0] cents;
      logic [1:0]         status;
   } dmp_rsp_type;

endpackage

>>> hdl/decimal_money_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_money_parser_top
// Parses a signed decimal money string, one character per transfer, into
// cents with an ok / empty / overflow / malformed status.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                               Dir  Moves
//  req      req_valid, req_ready, req_data      in   one character (+ end mark)
//  rsp      rsp_valid, rsp_ready, rsp_data      out  value and status per string
//
//  Takes one character per cycle while req_ready is high. For the transfer
//  marked last, the character stage finishes the digit accumulate
//  (shift-add of whole*10+d), a finish stage forms whole*100+frac with the
//  overflow check and the sign, and the output register holds it in rsp_data.
//  Synchronous active-high reset clears the parse state and both valid flags.
//  A stalled rsp side holds its result; the finish stage then stays full and
//  req_ready drops only while both it and the output register are full.
//
module decimal_money_parser_top
   import dmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dmp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dmp_rsp_type rsp_data
);

   // ---------------- parse state ----------------
   phase_type   phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [62:0] whole_ff, whole_in;
   logic [6:0]  frac_ff, frac_in;
   logic [1:0]  fdig_ff, fdig_in;
   logic        rds_ff, rds_in;      // third fraction digit taken
   logic        rup_ff, rup_in;      // that digit rounds up
   logic        saw_ff, saw_in;
   logic        ovf_ff, ovf_in;
   logic        mal_ff, mal_in;

   // state after this character, before the end-of-string clear
   phase_type   step_phase;
   logic        step_neg;
   logic [62:0] step_whole;
   logic [6:0]  step_frac;
   logic [1:0]  step_fdig;
   logic        step_rds;
   logic        step_rup;
   logic        step_saw;
   logic        step_ovf;
   logic        step_mal;
   logic [1:0]  step_status;

   // ---------------- finish stage ----------------
   logic        fin_valid_ff, fin_valid_in;
   logic [62:0] fin_whole_ff;
   logic [6:0]  fin_frac_ff;
   logic [1:0]  fin_fdig_ff;
   logic        fin_rup_ff;
   logic        fin_neg_ff;
   logic [1:0]  fin_status_ff;

   // ---------------- output register ----------------
   logic        rsp_valid_ff, rsp_valid_in;
   dmp_rsp_type rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        out_load;
   logic        fin_free;
   logic        is_digit;
   logic [3:0]  digit;
   logic        is_sign;
   logic        is_empty;
   logic        end_fire;

   logic [6:0]  frac_adj;
   logic [69:0] whole_ext;
   logic [69:0] total;
   logic        total_ovf;
   logic [63:0] mag;

   // ---------------- handshake ----------------
   assign out_load  = fin_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign fin_free  = !fin_valid_ff || out_load;
   assign req_ready = fin_free;
   assign req_fire  = req_valid && req_ready;
   assign end_fire  = req_fire && req_data.last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- character decode ----------------
   assign is_digit = (req_data.ch >= CH_ZERO) && (req_data.ch <= CH_NINE);
   assign digit    = is_digit ? 4'(req_data.ch - CH_ZERO) : 4'd0;
   assign is_sign  = (req_data.ch == CH_MINUS) || (req_data.ch == CH_PLUS);
   assign is_empty = !req_data.has_char && (phase_ff == PH_START);

   // One character step. Once an error flag is up the rest is ignored.
   always_comb begin
      step_phase = phase_ff;
      step_neg   = neg_ff;
      step_whole = whole_ff;
      step_frac  = frac_ff;
      step_fdig  = fdig_ff;
      step_rds   = rds_ff;
      step_rup   = rup_ff;
      step_saw   = saw_ff;
      step_ovf   = ovf_ff;
      step_mal   = mal_ff;
      if (req_data.has_char && !ovf_ff && !mal_ff) begin
         if ((phase_ff == PH_START) && is_sign) begin
            step_neg   = (req_data.ch == CH_MINUS);
            step_phase = PH_WHOLE;
         end else if ((phase_ff == PH_START) || (phase_ff == PH_WHOLE)) begin
            step_phase = PH_WHOLE;
            if (is_digit) begin
               step_saw = 1'b1;
               if (whole_ff > WHOLE_LIMIT) begin
                  step_ovf = 1'b1;
               end else begin
                  // whole*10 + d as shift-add; fits since whole <= limit
                  step_whole = 63'((whole_ff << 3) + (whole_ff << 1) + {59'd0, digit});
               end
            end else if (req_data.ch == CH_POINT) begin
               step_phase = PH_FRAC;
            end else begin
               step_mal = 1'b1;
            end
         end else begin
            if (is_digit) begin
               step_saw = 1'b1;
               if (fdig_ff < 2'd2) begin
                  step_frac = 7'((frac_ff << 3) + (frac_ff << 1) + {3'd0, digit});
                  step_fdig = 2'(fdig_ff + 2'd1);
               end else if (!rds_ff) begin
                  step_rds = 1'b1;
                  step_rup = (digit >= ROUND_DIGIT);
               end
            end else begin
               step_mal = 1'b1;
            end
         end
      end
   end

   // Status decided at the end mark; ok may still turn into overflow later.
   always_comb begin
      if (is_empty) begin
         step_status = ST_EMPTY;
      end else if (step_ovf) begin
         step_status = ST_OVERFLOW;
      end else if (step_mal || !step_saw) begin
         step_status = ST_MALFORMED;
      end else begin
         step_status = ST_OK;
      end
   end

   // Next parse state: take the step on a real item, clear after the end mark.
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      whole_in = whole_ff;
      frac_in  = frac_ff;
      fdig_in  = fdig_ff;
      rds_in   = rds_ff;
      rup_in   = rup_ff;
      saw_in   = saw_ff;
      ovf_in   = ovf_ff;
      mal_in   = mal_ff;
      if (end_fire) begin
         phase_in = PH_START;
         neg_in   = 1'b0;
         whole_in = '0;
         frac_in  = '0;
         fdig_in  = '0;
         rds_in   = 1'b0;
         rup_in   = 1'b0;
         saw_in   = 1'b0;
         ovf_in   = 1'b0;
         mal_in   = 1'b0;
      end else if (req_fire) begin
         phase_in = step_phase;
         neg_in   = step_neg;
         whole_in = step_whole;
         frac_in  = step_frac;
         fdig_in  = step_fdig;
         rds_in   = step_rds;
         rup_in   = step_rup;
         saw_in   = step_saw;
         ovf_in   = step_ovf;
         mal_in   = step_mal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         neg_ff   <= 1'b0;
         whole_ff <= '0;
         frac_ff  <= '0;
         fdig_ff  <= '0;
         rds_ff   <= 1'b0;
         rup_ff   <= 1'b0;
         saw_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         mal_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         whole_ff <= whole_in;
         frac_ff  <= frac_in;
         fdig_ff  <= fdig_in;
         rds_ff   <= rds_in;
         rup_ff   <= rup_in;
         saw_ff   <= saw_in;
         ovf_ff   <= ovf_in;
         mal_ff   <= mal_in;
      end
   end

   // ---------------- finish stage ----------------
   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (end_fire) begin
         fin_valid_in = 1'b1;
      end else if (out_load) begin
         fin_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_fire) begin
         fin_whole_ff  <= step_whole;
         fin_frac_ff   <= step_frac;
         fin_fdig_ff   <= step_fdig;
         fin_rup_ff    <= step_rup;
         fin_neg_ff    <= step_neg;
         fin_status_ff <= step_status;
      end
   end

   // single fraction digit counts tenths; round-up adds a cent (max 100)
   always_comb begin
      if (fin_fdig_ff == 2'd1) begin
         frac_adj = 7'((fin_frac_ff << 3) + (fin_frac_ff << 1) + {6'd0, fin_rup_ff});
      end else begin
         frac_adj = 7'(fin_frac_ff + {6'd0, fin_rup_ff});
      end
   end

   // whole*100 + frac exactly in 70 bits; anything above bit 62 overflows
   assign whole_ext = {7'd0, fin_whole_ff};
   assign total     = (whole_ext << 6) + (whole_ext << 5) + (whole_ext << 2)
                      + {63'd0, frac_adj};
   assign total_ovf = |total[69:63];
   assign mag       = total[63:0];

   always_comb begin
      rsp_data_in.cents  = '0;
      rsp_data_in.status = fin_status_ff;
      if (fin_status_ff == ST_OK) begin
         if (total_ovf) begin
            rsp_data_in.status = ST_OVERFLOW;
         end else if (fin_neg_ff) begin
            rsp_data_in.cents = -$signed(mag);
         end else begin
            rsp_data_in.cents = $signed(mag);
         end
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for decimal_money_parser_top. Feeds money strings one
// character per transfer (signs, digits, points, junk bytes, idle items, near
// the 64-bit limit) with random gaps on both channels. An in-bench parser
// predicts value and status per string, and each result is compared field by
// field in order.
// ----------------------------------------------------------------------------
module tb
   import dmp_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned ITEM_TARGET = 550;
   localparam logic [63:0] CENTS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

   // ------------------------------------------------------------------------
   // Clock, reset and block I/O. Every input has a known value from time 0.
   // ------------------------------------------------------------------------
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   dmp_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   dmp_rsp_type rsp_data;

   always #5 clock = ~clock;

   decimal_money_parser_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ------------------------------------------------------------------------
   // Stimulus store: one slot per req transfer, with the idle cycles that
   // precede it and an optional hold until every pending string has answered.
   // ------------------------------------------------------------------------
   typedef struct {
      dmp_req_type data;
      int unsigned gap;
      bit          drain;
   } char_slot_type;

   char_slot_type pending[$];
   logic [7:0]    text[$];        // string under construction
   int unsigned   items_queued   = 0;
   int unsigned   strings_queued = 0;
   bit            gaps_on        = 1'b0;
   bit            drain_next     = 1'b0;

   // handshake flags sampled at the rising edge, read by the drivers
   logic        req_fired = 1'b0;
   logic        rsp_fired = 1'b0;
   int unsigned cycles    = 0;

   // ------------------------------------------------------------------------
   // Predictor: a cycle-free copy of the parse state
   // ------------------------------------------------------------------------
   phase_type   p_phase       = PH_START;
   logic        p_negative    = 1'b0;
   logic [63:0] p_whole       = '0;
   logic [6:0]  p_frac        = '0;
   logic [1:0]  p_frac_digits = '0;
   logic        p_round_seen  = 1'b0;
   logic        p_round_up    = 1'b0;
   logic        p_saw_digit   = 1'b0;
   logic        p_overflow    = 1'b0;
   logic        p_malformed   = 1'b0;

   dmp_rsp_type parsed_due[$];    // predicted results, oldest first

   int unsigned mismatches   = 0;
   int unsigned results_seen = 0;
   int unsigned status_tally [4] = '{0, 0, 0, 0};

   function automatic void clear_parser();
      p_phase       = PH_START;
      p_negative    = 1'b0;
      p_whole       = '0;
      p_frac        = '0;
      p_frac_digits = '0;
      p_round_seen  = 1'b0;
      p_round_up    = 1'b0;
      p_saw_digit   = 1'b0;
      p_overflow    = 1'b0;
      p_malformed   = 1'b0;
   endfunction

   // Advances the parse by one accepted transfer; on last, queues the result.
   function automatic void step_parser(dmp_req_type it);
      logic        is_digit;
      logic [3:0]  d;
      logic        empty;
      logic [63:0] frac_cents;
      logic [63:0] mag;
      dmp_rsp_type r;
      if (!it.has_char && !it.last) return;          // idle item
      empty = !it.has_char && (p_phase == PH_START);
      if (it.has_char && !p_overflow && !p_malformed) begin
         is_digit = (it.ch >= CH_ZERO) && (it.ch <= CH_NINE);
         d = is_digit ? 4'(it.ch - CH_ZERO) : 4'd0;
         if (p_phase == PH_START && (it.ch == CH_MINUS || it.ch == CH_PLUS)) begin
            p_negative = (it.ch == CH_MINUS);
            p_phase    = PH_WHOLE;
         end else if (p_phase != PH_FRAC) begin
            p_phase = PH_WHOLE;
            if (is_digit) begin
               p_saw_digit = 1'b1;
               // check happens before the digit is folded in
               if (p_whole > {1'b0, WHOLE_LIMIT}) p_overflow = 1'b1;
               else p_whole = p_whole * 10 + 64'(d);
            end else if (it.ch == CH_POINT) begin
               p_phase = PH_FRAC;
            end else begin
               p_malformed = 1'b1;
            end
         end else if (is_digit) begin
            p_saw_digit = 1'b1;
            if (p_frac_digits < 2'd2) begin
               p_frac        = 7'(p_frac * 10 + d);
               p_frac_digits = p_frac_digits + 2'd1;
            end else if (!p_round_seen) begin
               p_round_seen = 1'b1;
               p_round_up   = (d >= ROUND_DIGIT);
            end
         end else begin
            p_malformed = 1'b1;
         end
      end
      if (!it.last) return;

      r.cents = '0;
      if (empty) begin
         r.status = ST_EMPTY;
      end else if (p_overflow) begin
         r.status = ST_OVERFLOW;
      end else if (p_malformed || !p_saw_digit) begin
         r.status = ST_MALFORMED;
      end else begin
         frac_cents = 64'(p_frac);
         if (p_frac_digits == 2'd1) frac_cents = frac_cents * 10;
         if (p_round_up) frac_cents = frac_cents + 1;
         if (p_whole > (CENTS_MAX - frac_cents) / 100) begin
            r.status = ST_OVERFLOW;
         end else begin
            mag      = p_whole * 100 + frac_cents;
            r.cents  = p_negative ? 64'd0 - mag : mag;
            r.status = ST_OK;
         end
      end
      parsed_due.push_back(r);
      clear_parser();
   endfunction

   function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
   endfunction

   // ------------------------------------------------------------------------
   // Monitor / scoreboard. Outputs are sampled at the rising edge; the
   // predictor runs first so a result can never overtake its own string.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      dmp_rsp_type want;
      req_fired <= !reset && req_valid && req_ready;
      rsp_fired <= !reset && rsp_valid && rsp_ready;
      if (reset) begin
         clear_parser();
      end else begin
         if (req_valid && req_ready) step_parser(req_data);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (parsed_due.size() == 0) begin
               note_mismatch("unexpected result", '0, rsp_data.cents);
            end else begin
               want = parsed_due.pop_front();
               status_tally[want.status]++;
               if (rsp_data.cents !== want.cents)
                  note_mismatch("cents", want.cents, rsp_data.cents);
               if (rsp_data.status !== want.status)
                  note_mismatch("status", 64'(want.status), 64'(rsp_data.status));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: changes req at the falling edge. Valid stays up across
   // back-to-back transfers; a drain slot holds off until the scoreboard
   // has nothing outstanding.
   // ------------------------------------------------------------------------
   int unsigned gap_left  = 0;
   bit          gap_armed = 1'b0;

   always @(negedge clock) begin : feed
      char_slot_type slot;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pending.size() != 0 && !gap_armed) begin
            gap_left  = pending[0].gap;
            gap_armed = 1'b1;
         end
         if (pending.size() == 0 || gap_left != 0 ||
             (pending[0].drain && parsed_due.size() != 0)) begin
            req_valid <= 1'b0;
            if (gap_left != 0) gap_left = gap_left - 1;
         end else begin
            slot      = pending.pop_front();
            gap_armed = 1'b0;
            req_data  <= slot.data;
            req_valid <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: after each rsp transfer draws a random stall, counted while a
   // result is offered. A recurring calm stretch keeps ready high
   // throughout.
   // ------------------------------------------------------------------------
   int unsigned stall_left = 0;

   always @(negedge clock) begin : sink
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_fired)
            stall_left = ((cycles % 1200) < 300) ? 0 : $urandom_range(0, 12);
         if (stall_left != 0 && rsp_valid) stall_left = stall_left - 1;
         rsp_ready <= (stall_left == 0);
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------
   function automatic void queue_item(logic [7:0] c, logic has, logic fin);
      char_slot_type s;
      s.data.ch       = c;
      s.data.has_char = has;
      s.data.last     = fin;
      s.gap           = gaps_on ? $urandom_range(0, 12) : 0;
      s.drain         = drain_next;
      drain_next      = 1'b0;
      pending.push_back(s);
      if (has || fin) items_queued++;
   endfunction

   // Ships the text as one string; an empty text always ends with a bare end.
   function automatic void send_text(bit bare_end, int unsigned idle_pct);
      int unsigned n;
      n = text.size();
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < idle_pct)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         queue_item(text[i], 1'b1, !bare_end && (i == n - 1));
      end
      if (bare_end || n == 0)
         queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      strings_queued++;
      text.delete();
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endfunction

   function automatic void add_digits(int unsigned n);
      repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_number(logic [63:0] v);
      logic [7:0] dq[$];
      do begin
         dq.push_front(CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (dq[i]) text.push_back(dq[i]);
   endfunction

   function automatic void add_sign();
      case ($urandom_range(0, 2))
         1: text.push_back(CH_PLUS);
         2: text.push_back(CH_MINUS);
         default: ;
      endcase
   endfunction

   function automatic void add_well_formed();
      int unsigned nd;
      add_sign();
      nd = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      add_digits(nd);
      if (nd == 0 || $urandom_range(0, 2) != 0) begin
         text.push_back(CH_POINT);
         add_digits($urandom_range(nd == 0 ? 1 : 0, 5));
      end
   endfunction

   // Magnitudes right at the 64-bit edges: the cents limit, the whole-digit
   // limit and long digit runs, some long enough to trip the overflow check.
   function automatic void add_boundary();
      add_sign();
      case ($urandom_range(0, 4))
         0: add_number(64'd92233720368547758);
         1: add_number(64'd92233720368547757);
         2: begin
            add_number({1'b0, WHOLE_LIMIT});
            if ($urandom_range(0, 1) != 0) add_digits(1);
         end
         3: begin
            add_number({1'b0, WHOLE_LIMIT} + 64'd1);
            add_digits(1);
         end
         default: add_digits($urandom_range(15, 22));
      endcase
      if ($urandom_range(0, 1) != 0) begin
         text.push_back(CH_POINT);
         add_digits($urandom_range(0, 3));
      end
   endfunction

   function automatic void build_random_string(int unsigned idx);
      int unsigned kind;
      logic [7:0]  junk;
      kind    = $urandom_range(0, 99);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (idx % 40 == 7) drain_next = 1'b1;
      if (kind < 62) begin
         add_well_formed();
      end else if (kind < 78) begin
         add_boundary();
      end else if (kind < 90) begin
         // well-formed body with one byte overwritten by a sign, point or random byte
         add_well_formed();
         case ($urandom_range(0, 3))
            0: junk = CH_MINUS;
            1: junk = CH_PLUS;
            2: junk = CH_POINT;
            default: junk = 8'($urandom_range(0, 255));
         endcase
         if (text.size() == 0) text.push_back(junk);
         else text[$urandom_range(0, text.size() - 1)] = junk;
      end else begin
         repeat ($urandom_range(0, 4)) text.push_back(8'($urandom_range(0, 255)));
      end
      send_text($urandom_range(0, 7) == 0, 5);
   endfunction

   // ------------------------------------------------------------------------
   // Sequence: fill the queue, release reset, wait for the scoreboard to
   // drain, then report.
   // ------------------------------------------------------------------------
   initial begin
      // directed part
      gaps_on = 1'b0;
      queue_item(8'hA5, 1'b0, 1'b0);         // idle item, ignored
      send_text(1'b1, 0);                    // empty string
      add_text("7");        send_text(1'b1, 0);  // bare end after a digit
      add_text("-0.995");   send_text(1'b0, 0);  // round-up carries into whole
      add_text("5.");       send_text(1'b0, 0);  // trailing point
      add_text("+12.3456"); send_text(1'b0, 0);  // digits past round ignored
      gaps_on = 1'b1;
      add_text("1..");      send_text(1'b0, 0);  // second point
      add_text("-");        send_text(1'b0, 0);  // lone sign
      add_text(".");        send_text(1'b0, 0);  // lone point
      add_text("1-");       send_text(1'b0, 0);  // sign not first
      text.push_back(8'hFF); send_text(1'b0, 0); // stray byte

      // random part
      for (int unsigned k = 0; items_queued < ITEM_TARGET; k++)
         build_random_string(k);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid || parsed_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);   // catch anything stray after the last result

      $display("Ran %0d strings in %0d transfers; %0d results compared, %0d mismatches",
               strings_queued, items_queued, results_seen, mismatches);
      $display("Statuses seen: ok %0d, empty %0d, overflow %0d, malformed %0d",
               status_tally[ST_OK], status_tally[ST_EMPTY],
               status_tally[ST_OVERFLOW], status_tally[ST_MALFORMED]);
      if (mismatches == 0 && parsed_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/dmp_pkg.sv
hdl/decimal_money_parser_top.sv
test/tb.sv
